// ===== hdl/brcc_pkg.sv =====
package brcc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned THR_W  = 16;

	// Minimum spacing between honored ticks, in milliseconds.
	localparam logic [TIME_W-1:0] TICK_MIN_MS = 32'd20;

	localparam logic [THR_W-1:0] LONG_PRESS_RST   = 16'd3000;
	localparam logic [THR_W-1:0] SINGLE_CLICK_RST = 16'd1000;
	localparam logic [THR_W-1:0] DOUBLE_WIN_RST   = 16'd300;

	localparam logic [1:0] CFG_LONG_PRESS   = 2'd0;
	localparam logic [1:0] CFG_SINGLE_CLICK = 2'd1;
	localparam logic [1:0] CFG_DOUBLE_WIN   = 2'd2;

	localparam logic [1:0] MODE_PRESS   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;

	typedef enum logic [3:0] {
		ACT_NONE          = 4'd0,
		ACT_ALL_OFF       = 4'd1,
		ACT_CANCEL_OFF    = 4'd2,
		ACT_SCAN          = 4'd3,
		ACT_MASTER_ON     = 4'd4,
		ACT_MASTER_TIMER  = 4'd5,
		ACT_SLAVE_ON      = 4'd6,
		ACT_SLAVE_JOIN    = 4'd7,
		ACT_MASTER_OFF    = 4'd8,
		ACT_FACTORY_RESET = 4'd9
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_WAIT    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] now_ms;
		logic              locked;
		logic              timer_running;
		logic              timer_from_detect;
		logic              master_on;
		logic              slave_on;
		logic              detect_scan_enabled;
		logic              auto_timer_enabled;
		logic              timer_enabled;
	} item_t;

	typedef struct packed {
		logic [THR_W-1:0] long_press_ms;
		logic [THR_W-1:0] single_click_ms;
		logic [THR_W-1:0] double_window_ms;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] press_start_ms;
		logic [TIME_W-1:0] window_start_ms;
		logic              second_press_seen;
		logic              window_opens_master;
		logic [TIME_W-1:0] last_tick_ms;
	} state_t;

endpackage

// ===== hdl/brcc_step.sv =====
module brcc_step (
	input  brcc_pkg::item_t   item,
	input  brcc_pkg::state_t  cur,
	input  brcc_pkg::cfg_t    cfg,
	output brcc_pkg::action_t action,
	output brcc_pkg::state_t  nxt
);

	logic [brcc_pkg::TIME_W-1:0] hold_ms;
	logic [brcc_pkg::TIME_W-1:0] since_tick_ms;
	logic [brcc_pkg::TIME_W-1:0] since_window_ms;
	logic                        is_long;
	logic                        is_short;
	logic                        window_done;

	assign hold_ms         = item.now_ms - cur.press_start_ms;
	assign since_tick_ms   = item.now_ms - cur.last_tick_ms;
	assign since_window_ms = item.now_ms - cur.window_start_ms;
	assign is_long     = hold_ms >= {16'd0, cfg.long_press_ms};
	assign is_short    = hold_ms < {16'd0, cfg.single_click_ms};
	assign window_done = since_window_ms >= {16'd0, cfg.double_window_ms};

	always_comb begin
		nxt    = cur;
		action = brcc_pkg::ACT_NONE;
		case (item.mode)
			brcc_pkg::MODE_PRESS: begin
				nxt.press_start_ms = item.now_ms;
				if (!item.locked) begin
					nxt.second_press_seen = (cur.phase == brcc_pkg::PH_WAIT);
					nxt.phase             = brcc_pkg::PH_PRESSED;
					if (cur.phase == brcc_pkg::PH_WAIT) begin
						action = item.timer_running ? brcc_pkg::ACT_SLAVE_JOIN
						                            : brcc_pkg::ACT_SLAVE_ON;
					end
				end
			end
			brcc_pkg::MODE_RELEASE: begin
				if (item.timer_running && item.timer_from_detect) begin
					action = brcc_pkg::ACT_CANCEL_OFF;
				end else if (item.locked) begin
					if (is_long) begin
						action = brcc_pkg::ACT_ALL_OFF;
					end else if (is_short && item.detect_scan_enabled) begin
						action = brcc_pkg::ACT_SCAN;
					end
				end else if (cur.phase == brcc_pkg::PH_PRESSED) begin
					nxt.phase = brcc_pkg::PH_IDLE;
					if (cur.second_press_seen) begin
						nxt.second_press_seen = 1'b0;
					end else if (!is_long && is_short) begin
						if (!item.master_on && !item.slave_on) begin
							action = (item.auto_timer_enabled && item.timer_enabled)
							       ? brcc_pkg::ACT_MASTER_TIMER : brcc_pkg::ACT_MASTER_ON;
							nxt.window_opens_master = 1'b1;
							nxt.window_start_ms     = item.now_ms;
							nxt.phase               = brcc_pkg::PH_WAIT;
						end else if (item.master_on && !item.slave_on) begin
							nxt.window_opens_master = 1'b0;
							nxt.window_start_ms     = item.now_ms;
							nxt.phase               = brcc_pkg::PH_WAIT;
						end else begin
							action = brcc_pkg::ACT_ALL_OFF;
						end
					end
				end else begin
					nxt.phase = brcc_pkg::PH_IDLE;
				end
			end
			brcc_pkg::MODE_TICK: begin
				if (since_tick_ms >= brcc_pkg::TICK_MIN_MS) begin
					nxt.last_tick_ms = item.now_ms;
					if (!item.locked && cur.phase == brcc_pkg::PH_PRESSED && is_long) begin
						// Factory reset wipes everything but the tick time.
						action                  = brcc_pkg::ACT_FACTORY_RESET;
						nxt.phase               = brcc_pkg::PH_IDLE;
						nxt.press_start_ms      = '0;
						nxt.window_start_ms     = '0;
						nxt.second_press_seen   = 1'b0;
						nxt.window_opens_master = 1'b0;
					end else if (cur.phase == brcc_pkg::PH_WAIT && window_done) begin
						if (!cur.window_opens_master) begin
							action = brcc_pkg::ACT_MASTER_OFF;
						end
						nxt.phase = brcc_pkg::PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/button_relay_click_controller_top.sv =====
// Channel  Direction  Ports                       Payload
// s_*      in         s_tvalid s_tready s_tdata   tdata: event snapshot, tuser: mode
//                     s_tuser
// m_*      out        m_tvalid m_tready m_tdata   tdata: action, fsm_phase
// cfg_*    in         cfg_valid cfg_ready         cfg_addr: register, cfg_data: value
//                     cfg_addr cfg_data
//
// An event is registered, then evaluated combinationally against the state; its
// result goes to the output register: one event per cycle unless the output stalls.
// The state registers update when the event moves into the output register.
// A stalled output holds the input register; input is taken whenever that stage
// frees up in the same cycle. Reset returns state and thresholds to their defaults.
module button_relay_click_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] now_ms, [32] locked, [33] timer_running, [34] timer_from_detect,
	// [35] master_on, [36] slave_on, [37] detect_scan_enabled,
	// [38] auto_timer_enabled, [39] timer_enabled
	input  logic [39:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] action, [5:4] fsm_phase, [7:6] zero
	output logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_data
);

	brcc_pkg::item_t   item_s1;
	logic              valid_s1;
	brcc_pkg::cfg_t    cfg_q;
	brcc_pkg::state_t  state_q;
	brcc_pkg::state_t  state_nxt;
	brcc_pkg::action_t action_nxt;
	brcc_pkg::action_t action_s2;
	brcc_pkg::phase_t  phase_s2;
	logic              valid_s2;
	logic              adv;

	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= {s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[33], s_tdata[34],
			            s_tdata[35], s_tdata[36], s_tdata[37], s_tdata[38], s_tdata[39]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms    <= brcc_pkg::LONG_PRESS_RST;
			cfg_q.single_click_ms  <= brcc_pkg::SINGLE_CLICK_RST;
			cfg_q.double_window_ms <= brcc_pkg::DOUBLE_WIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				brcc_pkg::CFG_LONG_PRESS:   cfg_q.long_press_ms    <= cfg_data;
				brcc_pkg::CFG_SINGLE_CLICK: cfg_q.single_click_ms  <= cfg_data;
				brcc_pkg::CFG_DOUBLE_WIN:   cfg_q.double_window_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	brcc_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.cfg    (cfg_q),
		.action (action_nxt),
		.nxt    (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase               <= brcc_pkg::PH_IDLE;
			state_q.press_start_ms      <= '0;
			state_q.window_start_ms     <= '0;
			state_q.second_press_seen   <= 1'b0;
			state_q.window_opens_master <= 1'b0;
			state_q.last_tick_ms        <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s2 <= action_nxt;
			phase_s2  <= state_nxt.phase;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, phase_s2, action_s2};

`ifndef SYNTHESIS
	// The phase reported with a result is the phase the state holds afterward.
	a_phase_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (phase_s2 == state_q.phase))
		else $error("reported phase differs from stored phase");

	a_reset_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && action_s2 == brcc_pkg::ACT_FACTORY_RESET) |->
		(phase_s2 == brcc_pkg::PH_IDLE && !state_q.second_press_seen))
		else $error("factory reset left a non-idle state");

	a_master_on_opens_window: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (action_s2 == brcc_pkg::ACT_MASTER_ON ||
		              action_s2 == brcc_pkg::ACT_MASTER_TIMER)) |->
		(phase_s2 == brcc_pkg::PH_WAIT))
		else $error("master-on click did not open the second-press window");
`endif

endmodule

// ===== dv/tb_button_relay_click_controller_top.sv =====
module tb_button_relay_click_controller_top;
	timeunit 1ns;
	timeprecision 1ps;

	import brcc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	// Flag bits of one event, in the order they sit above now_ms in s_tdata.
	localparam logic [7:0] F_LOCK = 8'h01;
	localparam logic [7:0] F_TRUN = 8'h02;
	localparam logic [7:0] F_TDET = 8'h04;
	localparam logic [7:0] F_MON  = 8'h08;
	localparam logic [7:0] F_SON  = 8'h10;
	localparam logic [7:0] F_SCAN = 8'h20;
	localparam logic [7:0] F_AUTO = 8'h40;
	localparam logic [7:0] F_TEN  = 8'h80;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		action_t act;
		phase_t  ph;
	} click_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = '0;
	logic [15:0] cfg_data = '0;

	// Predictor copy of thresholds and click state.
	logic [15:0] thr_long;
	logic [15:0] thr_short;
	logic [15:0] thr_win;
	phase_t      ph;
	logic [31:0] press_t;
	logic [31:0] win_t;
	logic [31:0] tick_t;
	logic        second_seen;
	logic        win_master;

	click_result_t expected_actions[$];
	click_result_t want;

	int          errors = 0;
	int          sent_count = 0;
	int          cycles = 0;
	int          stall_left = 0;
	bit          sender_idle = 1'b1;
	bit          stall_en = 1'b1;
	// While set, the random traffic keeps reshuffling idling on both sides.
	bit          idle_mix = 1'b1;
	logic [31:0] t_ms;

	button_relay_click_controller_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!stall_en) begin
			m_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_actions.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_actions.pop_front();
				if (m_tdata[3:0] !== want.act) begin
					$display("%0t: action expected %0d actual %0d",
						$time, want.act, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[5:4] !== want.ph) begin
					$display("%0t: fsm_phase expected %0d actual %0d",
						$time, want.ph, m_tdata[5:4]);
					errors++;
				end
			end
		end
	end

	task automatic predict_click_action(input item_t ev, output action_t act, output phase_t ph_o);
		logic [31:0] held;
		act = ACT_NONE;
		held = ev.now_ms - press_t;
		case (ev.mode)
			MODE_PRESS: begin
				press_t = ev.now_ms;
				if (!ev.locked) begin
					second_seen = 1'b0;
					if (ph == PH_WAIT) begin
						second_seen = 1'b1;
						act = ev.timer_running ? ACT_SLAVE_JOIN : ACT_SLAVE_ON;
					end
					ph = PH_PRESSED;
				end
			end
			MODE_RELEASE: begin
				if (ev.timer_running && ev.timer_from_detect) begin
					act = ACT_CANCEL_OFF;
				end else if (ev.locked) begin
					if (held >= thr_long)
						act = ACT_ALL_OFF;
					else if (held < thr_short && ev.detect_scan_enabled)
						act = ACT_SCAN;
				end else if (ph == PH_PRESSED) begin
					if (second_seen) begin
						second_seen = 1'b0;
						ph = PH_IDLE;
					end else if (held >= thr_long) begin
						ph = PH_IDLE;
					end else if (held < thr_short) begin
						if (!ev.master_on && !ev.slave_on) begin
							act = (ev.auto_timer_enabled && ev.timer_enabled) ?
								ACT_MASTER_TIMER : ACT_MASTER_ON;
							win_master = 1'b1;
							win_t = ev.now_ms;
							ph = PH_WAIT;
						end else if (ev.master_on && !ev.slave_on) begin
							win_master = 1'b0;
							win_t = ev.now_ms;
							ph = PH_WAIT;
						end else begin
							act = ACT_ALL_OFF;
							ph = PH_IDLE;
						end
					end else begin
						ph = PH_IDLE;
					end
				end else begin
					ph = PH_IDLE;
				end
			end
			MODE_TICK: begin
				if (ev.now_ms - tick_t >= TICK_MIN_MS) begin
					tick_t = ev.now_ms;
					if (!ev.locked && ph == PH_PRESSED && held >= thr_long) begin
						// A factory reset clears everything but the tick time.
						act = ACT_FACTORY_RESET;
						ph = PH_IDLE;
						press_t = '0;
						win_t = '0;
						second_seen = 1'b0;
						win_master = 1'b0;
					end else if (ph == PH_WAIT && ev.now_ms - win_t >= thr_win) begin
						if (!win_master)
							act = ACT_MASTER_OFF;
						ph = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
		ph_o = ph;
	endtask

	task automatic send_event(input logic [1:0] mode, input logic [31:0] now,
		input logic [7:0] fl);
		item_t         ev;
		click_result_t r;
		ev.mode = mode;
		ev.now_ms = now;
		ev.locked = fl[0];
		ev.timer_running = fl[1];
		ev.timer_from_detect = fl[2];
		ev.master_on = fl[3];
		ev.slave_on = fl[4];
		ev.detect_scan_enabled = fl[5];
		ev.auto_timer_enabled = fl[6];
		ev.timer_enabled = fl[7];
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fl, now};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		predict_click_action(ev, r.act, r.ph);
		expected_actions.push_back(r);
		sent_count++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_actions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LONG_PRESS:   thr_long = val;
			CFG_SINGLE_CLICK: thr_short = val;
			CFG_DOUBLE_WIN:   thr_win = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_flags();
		logic [7:0] f;
		f = 8'($urandom_range(0, 255));
		f = f & ~(F_LOCK | F_TRUN | F_TDET);
		if ($urandom_range(0, 7) == 0) f = f | F_LOCK;
		if ($urandom_range(0, 2) == 0) f = f | F_TRUN;
		if ($urandom_range(0, 1) == 0) f = f | F_TDET;
		return f;
	endfunction

	// Spans clustered around a threshold so both sides of each compare are hit.
	function automatic logic [31:0] pick_span(input logic [15:0] thr);
		logic [31:0] t32;
		t32 = {16'd0, thr};
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, t32 - 1);
			1: return t32 - 1;
			2: return t32;
			3: return t32 + 1;
			4: return $urandom_range(0, 2 * t32 + 2);
			default: return $urandom_range(0, 60);
		endcase
	endfunction

	task automatic click_sequence();
		logic [31:0] hold;
		logic [31:0] t_press;
		logic [7:0]  fl;
		fl = random_flags();
		t_ms += $urandom_range(20, 400);
		t_press = t_ms;
		send_event(MODE_PRESS, t_ms, fl);
		hold = $urandom_range(0, 1) ? pick_span(thr_long) : pick_span(thr_short);
		repeat ($urandom_range(0, 3)) begin
			t_ms += $urandom_range(0, hold / 2 + 25);
			send_event(MODE_TICK, t_ms, fl);
		end
		if ($urandom_range(0, 2) == 0)
			send_event(MODE_TICK, t_press + hold, fl);
		t_ms = t_press + hold;
		// Now and then the release is dropped, so the next press lands on a held button.
		if ($urandom_range(0, 5) != 0)
			send_event(MODE_RELEASE, t_ms, random_flags());
		if ($urandom_range(0, 1) == 0) begin
			t_ms += pick_span(thr_win);
			send_event(MODE_PRESS, t_ms, random_flags());
			t_ms += pick_span(thr_short);
			send_event(MODE_RELEASE, t_ms, random_flags());
		end
		repeat ($urandom_range(0, 4)) begin
			t_ms += $urandom_range(0, thr_win / 2 + 30);
			send_event(MODE_TICK, t_ms, random_flags());
		end
	endtask

	task automatic run_random(input int items);
		int          target;
		logic [31:0] noise_t;
		target = sent_count + items;
		while (sent_count < target) begin
			if (idle_mix && $urandom_range(0, 5) == 0) begin
				sender_idle = $urandom_range(0, 3) != 0;
				stall_en = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 7) == 0) begin
				noise_t = $urandom;
				if ($urandom_range(0, 1) == 0)
					t_ms = noise_t;
				send_event(2'($urandom_range(0, 3)), noise_t, 8'($urandom_range(0, 255)));
			end else begin
				click_sequence();
			end
		end
	endtask

	task automatic test_directed_defaults();
		send_event(MODE_TICK, 32'd0, 8'h00);
		send_event(MODE_RELEASE, 32'd5, 8'h00);
		send_event(MODE_UNUSED, 32'd7, 8'hFF);
		send_event(MODE_PRESS, 32'd100, 8'h00);
		send_event(MODE_PRESS, 32'd150, 8'h00);
		send_event(MODE_RELEASE, 32'd250, F_AUTO | F_TEN);
		send_event(MODE_PRESS, 32'd400, 8'h00);
		send_event(MODE_RELEASE, 32'd450, 8'h00);
		send_event(MODE_PRESS, 32'd1000, F_MON);
		send_event(MODE_RELEASE, 32'd1100, F_MON);
		send_event(MODE_TICK, 32'd1400, F_MON);
		send_event(MODE_PRESS, 32'd2000, F_MON | F_SON);
		send_event(MODE_RELEASE, 32'd2050, F_MON | F_SON);
		send_event(MODE_PRESS, 32'd3000, 8'h00);
		send_event(MODE_RELEASE, 32'd4500, 8'h00);
		send_event(MODE_PRESS, 32'd5000, 8'h00);
		send_event(MODE_TICK, 32'd7999, 8'h00);
		send_event(MODE_TICK, 32'd8000, 8'h00);
		send_event(MODE_TICK, 32'd8020, 8'h00);
		send_event(MODE_PRESS, 32'd9000, 8'h00);
		send_event(MODE_RELEASE, 32'd9050, F_TRUN | F_TDET);
		send_event(MODE_RELEASE, 32'd16000, F_LOCK);
		send_event(MODE_PRESS, 32'd17000, F_LOCK);
		send_event(MODE_RELEASE, 32'd17010, F_LOCK | F_SCAN);
		send_event(MODE_PRESS, 32'hFFFF_FF00, 8'h00);
		send_event(MODE_RELEASE, 32'h0000_0010, F_AUTO);
		send_event(MODE_PRESS, 32'h0000_0020, F_TRUN);
		t_ms = 32'h0000_0100;
	endtask

	task automatic test_threshold_extremes();
		drain_results();
		write_threshold(CFG_LONG_PRESS, 16'd1);
		write_threshold(CFG_SINGLE_CLICK, 16'd1);
		write_threshold(CFG_DOUBLE_WIN, 16'd1);
		run_random(150);
		drain_results();
		write_threshold(CFG_LONG_PRESS, 16'hFFFF);
		write_threshold(CFG_SINGLE_CLICK, 16'hFFFF);
		write_threshold(CFG_DOUBLE_WIN, 16'hFFFF);
		run_random(150);
	endtask

	task automatic test_overlapping_thresholds();
		drain_results();
		write_threshold(CFG_LONG_PRESS, 16'd400);
		write_threshold(CFG_SINGLE_CLICK, 16'd1500);
		write_threshold(CFG_DOUBLE_WIN, 16'($urandom_range(1, 1000)));
		run_random(150);
	endtask

	task automatic test_random_settings();
		for (int round = 0; round < 4; round++) begin
			drain_results();
			write_threshold(CFG_LONG_PRESS, 16'($urandom_range(1, 5000)));
			write_threshold(CFG_SINGLE_CLICK, 16'($urandom_range(1, 3000)));
			write_threshold(CFG_DOUBLE_WIN,
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
				                                : $urandom_range(1, 800)));
			// The unused index must leave every threshold alone.
			if (round == 1)
				write_threshold(CFG_UNUSED, 16'($urandom_range(0, 65535)));
			run_random(150);
		end
	endtask

	task automatic test_sender_hold_off();
		drain_results();
		write_threshold(CFG_LONG_PRESS, LONG_PRESS_RST);
		write_threshold(CFG_SINGLE_CLICK, SINGLE_CLICK_RST);
		write_threshold(CFG_DOUBLE_WIN, DOUBLE_WIN_RST);
		repeat (3) begin
			run_random(50);
			drain_results();
		end
	endtask

	task automatic test_no_idle();
		drain_results();
		idle_mix = 1'b0;
		sender_idle = 1'b0;
		stall_en = 1'b0;
		write_threshold(CFG_LONG_PRESS, 16'($urandom_range(1, 3000)));
		write_threshold(CFG_SINGLE_CLICK, 16'($urandom_range(1, 3000)));
		write_threshold(CFG_DOUBLE_WIN, 16'($urandom_range(1, 500)));
		run_random(250);
	endtask

	initial begin
		thr_long = LONG_PRESS_RST;
		thr_short = SINGLE_CLICK_RST;
		thr_win = DOUBLE_WIN_RST;
		ph = PH_IDLE;
		press_t = '0;
		win_t = '0;
		tick_t = '0;
		second_seen = 1'b0;
		win_master = 1'b0;
		t_ms = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_threshold_extremes();
		test_overlapping_thresholds();
		test_random_settings();
		test_sender_hold_off();
		test_no_idle();

		drain_results();
		repeat (8) @(posedge clk);
		if (expected_actions.size() != 0) begin
			$display("%0t: results expected %0d actual 0",
				$time, expected_actions.size());
			errors++;
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/brcc_pkg.sv
hdl/brcc_step.sv
hdl/button_relay_click_controller_top.sv
dv/tb_button_relay_click_controller_top.sv
